// File: rtl/adc_code_to_temperature_lut_unit_assert.svh
// Assertion macros for the ADC code to temperature unit.
// ATLU_ASSERT checks a property on every clock edge outside reset.
// ATLU_ASSERT_ALWAYS checks a property on every clock edge, reset included.
`ifndef ADC_CODE_TO_TEMPERATURE_LUT_UNIT_ASSERT_SVH
`define ADC_CODE_TO_TEMPERATURE_LUT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ATLU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATLU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATLU_ASSERT(lbl, prop, msg)
`define ATLU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/atlu_pkg.sv
package atlu_pkg;

  localparam int ROM_LEN       = 211;
  localparam int STEPS_PER_SEG = 10;
  localparam int LAST_SEG      = 20;

  localparam logic [22:0] FULL_SCALE   = 23'd8388607;
  localparam logic [14:0] CODE_SCALE   = 15'd25000;
  localparam logic [14:0] UNDER_CODE   = 15'd9126;
  localparam logic [13:0] OVER_TENTHS  = 14'd9999;
  localparam logic [15:0] DIV10_RECIP  = 16'd52429;

  // configuration register indexes
  localparam logic [2:0] REG_TRIM       = 3'd0;
  localparam logic [2:0] REG_TRIM_GATE  = 3'd1;
  localparam logic [2:0] REG_DISC_LIMIT = 3'd2;
  localparam logic [2:0] REG_VALID_MAX  = 3'd3;
  localparam logic [2:0] REG_DISC_CODE  = 3'd4;
  localparam logic [2:0] REG_CLAMP_CODE = 3'd5;

  localparam logic [15:0] CAL_ROM [0:ROM_LEN-1] = '{
    16'd10000, 16'd10039, 16'd10078, 16'd10117, 16'd10156, 16'd10195, 16'd10234,
    16'd10273, 16'd10312, 16'd10351, 16'd10390, 16'd10429, 16'd10468, 16'd10507,
    16'd10546, 16'd10585, 16'd10624, 16'd10663, 16'd10702, 16'd10740, 16'd10779,
    16'd10818, 16'd10857, 16'd10896, 16'd10935, 16'd10973, 16'd11012, 16'd11051,
    16'd11090, 16'd11129, 16'd11167, 16'd11206, 16'd11245, 16'd11283, 16'd11322,
    16'd11361, 16'd11400, 16'd11438, 16'd11477, 16'd11515, 16'd11554, 16'd11593,
    16'd11631, 16'd11670, 16'd11708, 16'd11747, 16'd11786, 16'd11824, 16'd11863,
    16'd11901, 16'd11940, 16'd11978, 16'd12017, 16'd12055, 16'd12094, 16'd12132,
    16'd12171, 16'd12209, 16'd12247, 16'd12286, 16'd12324, 16'd12363, 16'd12401,
    16'd12439, 16'd12478, 16'd12516, 16'd12554, 16'd12593, 16'd12631, 16'd12669,
    16'd12708, 16'd12746, 16'd12784, 16'd12822, 16'd12861, 16'd12899, 16'd12937,
    16'd12975, 16'd13013, 16'd13050, 16'd13090, 16'd13128, 16'd13166, 16'd13204,
    16'd13242, 16'd13280, 16'd13318, 16'd13357, 16'd13395, 16'd13433, 16'd13471,
    16'd13509, 16'd13547, 16'd13585, 16'd13623, 16'd13661, 16'd13699, 16'd13737,
    16'd13775, 16'd13813, 16'd13851, 16'd13888, 16'd13926, 16'd13964, 16'd14002,
    16'd14040, 16'd14078, 16'd14116, 16'd14154, 16'd14191, 16'd14229, 16'd14267,
    16'd14305, 16'd14343, 16'd14380, 16'd14418, 16'd14456, 16'd14494, 16'd14531,
    16'd14569, 16'd14607, 16'd14644, 16'd14682, 16'd14720, 16'd14757, 16'd14795,
    16'd14833, 16'd14870, 16'd14908, 16'd14946, 16'd14983, 16'd15021, 16'd15058,
    16'd15096, 16'd15133, 16'd15171, 16'd15208, 16'd15246, 16'd15283, 16'd15321,
    16'd15358, 16'd15396, 16'd15433, 16'd15471, 16'd15508, 16'd15546, 16'd15583,
    16'd15620, 16'd15658, 16'd15695, 16'd15733, 16'd15770, 16'd15807, 16'd15845,
    16'd15882, 16'd15919, 16'd15956, 16'd16031, 16'd16068, 16'd16105, 16'd16105,
    16'd16143, 16'd16180, 16'd16217, 16'd16254, 16'd16291, 16'd16329, 16'd16366,
    16'd16403, 16'd16440, 16'd16477, 16'd16514, 16'd16551, 16'd16589, 16'd16626,
    16'd16663, 16'd16700, 16'd16737, 16'd16774, 16'd16811, 16'd16848, 16'd16885,
    16'd16922, 16'd16959, 16'd16996, 16'd17033, 16'd17070, 16'd17107, 16'd17143,
    16'd17180, 16'd17217, 16'd17254, 16'd17291, 16'd17328, 16'd17365, 16'd17402,
    16'd17438, 16'd17475, 16'd17512, 16'd17549, 16'd17586, 16'd17622, 16'd17659,
    16'd17696, 16'd17733, 16'd17769, 16'd17806, 16'd17843, 16'd17879, 16'd17916,
    16'd17953
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_QUOT, ST_SEG, ST_STEP, ST_DIV, ST_TRIM, ST_FIN
  } atlu_state_t;

  typedef struct packed {
    logic [7:0]  trim;
    logic [13:0] trim_gate;
    logic [13:0] disc_limit;
    logic [9:0]  valid_max;
    logic [15:0] disc_code;
    logic [15:0] clamp_code;
  } atlu_cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic quot;
    logic seg_adv;
    logic step_go;
    logic step_adv;
    logic set_spec;
    logic spec_hi;
    logic div_go;
    logic div_adv;
    logic trim;
    logic fin;
  } atlu_cmd_t;

  typedef struct packed {
    logic under;
    logic seg_hit;
    logic seg_last;
    logic step_hit;
    logic step_last;
    logic div_last;
    logic out_free;
  } atlu_stat_t;

endpackage

// File: rtl/atlu_ctrl.sv
module atlu_ctrl import atlu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  atlu_stat_t stat,
  output atlu_cmd_t  cmd
);

  atlu_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.quot  = 1'b1;
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        if (stat.under) begin
          cmd.set_spec = 1'b1;
          state_nxt    = ST_TRIM;
        end else if (stat.seg_hit) begin
          cmd.step_go = 1'b1;
          state_nxt   = ST_STEP;
        end else if (stat.seg_last) begin
          cmd.set_spec = 1'b1;
          cmd.spec_hi  = 1'b1;
          state_nxt    = ST_TRIM;
        end else begin
          cmd.seg_adv = 1'b1;
        end
      end
      ST_STEP: begin
        if (stat.step_hit) begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_DIV;
        end else if (stat.step_last) begin
          cmd.set_spec = 1'b1;
          state_nxt    = ST_TRIM;
        end else begin
          cmd.step_adv = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_adv = 1'b1;
        if (stat.div_last) state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/atlu_datapath.sv
module atlu_datapath import atlu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [23:0] in_tdata,
  input  atlu_cfg_t   cfg,
  input  atlu_cmd_t   cmd,
  output atlu_stat_t  stat,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic [22:0] raw_r;
  logic [37:0] prod_r;
  logic [14:0] q_r;
  logic [4:0]  seg_r;
  logic [3:0]  step_r;
  logic        spec_r, spec_hi_r;
  logic [11:0] tb_r;
  logic [17:0] rem_r;
  logic [14:0] span_r;
  logic [1:0]  cnt_r;
  logic [3:0]  quo_r;
  logic [13:0] tenths_r, trimmed_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  // scaling: floor(P / (2^23 - 1)) with one correction
  logic [14:0] q_hi;
  logic [23:0] q_rem;
  logic [14:0] q_nxt;
  assign q_hi  = prod_r[37:23];
  assign q_rem = {1'b0, prod_r[22:0]} + 24'(q_hi);
  assign q_nxt = q_hi + 15'(q_rem >= {1'b0, FULL_SCALE});

  // segment and step bounds from the table
  logic [7:0]  seg_base, seg_top, step_lo_idx, step_hi_idx;
  logic [15:0] seg_lo, seg_hi, step_lo, step_hi;
  logic [15:0] q_ext;
  assign q_ext       = {1'b0, q_r};
  assign seg_base    = 8'(seg_r) * 8'(STEPS_PER_SEG);
  assign seg_top     = seg_base + 8'(STEPS_PER_SEG);
  assign step_lo_idx = seg_base + 8'(step_r);
  assign step_hi_idx = step_lo_idx + 8'd1;
  assign seg_lo      = CAL_ROM[seg_base];
  assign seg_hi      = CAL_ROM[seg_top];
  assign step_lo     = CAL_ROM[step_lo_idx];
  assign step_hi     = CAL_ROM[step_hi_idx];

  assign stat.under     = (q_r > UNDER_CODE) && (q_ext < CAL_ROM[0]);
  assign stat.seg_hit   = (q_ext >= seg_lo) && (q_ext < seg_hi);
  assign stat.seg_last  = (seg_r == 5'(LAST_SEG));
  assign stat.step_hit  = (q_ext >= step_lo) && (q_ext < step_hi);
  assign stat.step_last = (step_r == 4'(STEPS_PER_SEG - 1));
  assign stat.div_last  = (cnt_r == 2'd0);
  assign stat.out_free  = !out_valid_r || out_tready;

  // one quotient bit per cycle of the fraction divide
  logic [17:0] trial;
  assign trial = {3'b0, span_r} << cnt_r;

  // tenths assembly and trim
  logic [13:0] tenths_nxt;
  assign tenths_nxt = spec_r ? (spec_hi_r ? OVER_TENTHS : 14'd0)
                             : 14'(tb_r) + 14'(quo_r);

  // output formatting
  logic [29:0] deg_prod;
  logic [9:0]  deg;
  logic        disc;
  logic [15:0] temp;
  assign deg_prod = trimmed_r * DIV10_RECIP;
  assign deg      = deg_prod[28:19];
  assign disc     = trimmed_r > cfg.disc_limit;
  assign temp     = disc ? cfg.disc_code
                         : ((deg > cfg.valid_max) ? cfg.clamp_code : 16'(deg));

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.load) raw_r <= in_tdata[23] ? 23'd0 : in_tdata[22:0];
    if (cmd.mul)  prod_r <= raw_r * CODE_SCALE;
    if (cmd.quot) begin
      q_r    <= q_nxt;
      seg_r  <= '0;
      spec_r <= 1'b0;
    end
    if (cmd.seg_adv)  seg_r <= seg_r + 5'd1;
    if (cmd.step_go)  step_r <= '0;
    if (cmd.step_adv) step_r <= step_r + 4'd1;
    if (cmd.set_spec) begin
      spec_r    <= 1'b1;
      spec_hi_r <= cmd.spec_hi;
    end
    if (cmd.div_go) begin
      rem_r  <= 18'(q_ext - step_lo) * 18'd10;
      span_r <= 15'(step_hi - step_lo);
      tb_r   <= 12'(seg_r) * 12'd100 + 12'(step_r) * 12'd10;
      cnt_r  <= 2'd3;
      quo_r  <= '0;
    end
    if (cmd.div_adv) begin
      if (rem_r >= trial) begin
        rem_r        <= rem_r - trial;
        quo_r[cnt_r] <= 1'b1;
      end
      cnt_r <= cnt_r - 2'd1;
    end
    if (cmd.trim) begin
      tenths_r <= tenths_nxt;
      if (tenths_nxt > cfg.trim_gate) begin
        trimmed_r <= (tenths_nxt > 14'(cfg.trim)) ? tenths_nxt - 14'(cfg.trim) : 14'd0;
      end else begin
        trimmed_r <= tenths_nxt;
      end
    end
    if (cmd.fin) out_data_r <= {1'b0, !disc, tenths_r, temp};
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/adc_code_to_temperature_lut_unit.sv
// ADC code to temperature conversion through a piecewise-linear calibration table.
// Input stream: in_tdata[23:0] carries one signed ADC code per transfer.
// Output stream: one result per input; out_tdata holds temp_degrees [15:0],
// tenths_result [29:16], read_ok [30], zero in bit 31.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high, indexes past the last register are dropped.
// The segment scan over the table boundaries (one segment a cycle, up to 21),
// the step scan inside the segment (up to 10) and the fraction divide set the
// time from input transfer to out_tvalid. One item is in work at a time;
// in_tready is high only while the unit waits for input.
// The finished result sits in an output register, so the next code is taken
// while the receiver stalls; the unit waits at the end of that next item
// until the register frees up.
// Synchronous active-low reset empties the output register, returns the
// controller to idle and loads the register defaults.
`include "adc_code_to_temperature_lut_unit_assert.svh"
module adc_code_to_temperature_lut_unit import atlu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_code [23:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // temp_degrees [15:0], tenths_result [29:16], read_ok [30]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  atlu_cfg_t  cfg_r;
  atlu_cmd_t  cmd;
  atlu_stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trim       <= 8'd25;
      cfg_r.trim_gate  <= 14'd100;
      cfg_r.disc_limit <= 14'd9000;
      cfg_r.valid_max  <= 10'd390;
      cfg_r.disc_code  <= 16'd65535;
      cfg_r.clamp_code <= 16'd390;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRIM:       cfg_r.trim       <= cfg_data[7:0];
        REG_TRIM_GATE:  cfg_r.trim_gate  <= cfg_data[13:0];
        REG_DISC_LIMIT: cfg_r.disc_limit <= cfg_data[13:0];
        REG_VALID_MAX:  cfg_r.valid_max  <= cfg_data[9:0];
        REG_DISC_CODE:  cfg_r.disc_code  <= cfg_data;
        REG_CLAMP_CODE: cfg_r.clamp_code <= cfg_data;
        default: ;
      endcase
    end
  end

  atlu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  atlu_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ATLU_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "second item taken while busy")
  `ATLU_ASSERT(a_tenths_range, out_tvalid |-> (out_tdata[29:16] <= 14'd9999), "tenths out of range")
  `ATLU_ASSERT(a_disc_code, (out_tvalid && !out_tdata[30]) |-> (out_tdata[15:0] == cfg_r.disc_code), "disconnect code mismatch")
  `ATLU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

// File: tb/tb_adc_code_to_temperature_lut_unit.sv
`timescale 1ns / 100ps
module tb_adc_code_to_temperature_lut_unit;
  import atlu_pkg::*;

  typedef struct {
    logic [15:0] temp;
    logic [13:0] tenths;
    logic        ok;
  } reading_t;

  // calibration-table predictor plus the queue of expected readings
  class reading_board;
    int unsigned trim, gate, disc_limit, vmax, disc_code, clamp_code;
    reading_t    pending[$];
    int          errors;

    function void defaults();
      trim = 25; gate = 100; disc_limit = 9000; vmax = 390;
      disc_code = 65535; clamp_code = 390;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_TRIM:       trim = val[7:0];
        REG_TRIM_GATE:  gate = val[13:0];
        REG_DISC_LIMIT: disc_limit = val[13:0];
        REG_VALID_MAX:  vmax = val[9:0];
        REG_DISC_CODE:  disc_code = val;
        REG_CLAMP_CODE: clamp_code = val;
        default: ;
      endcase
    endfunction

    function int unsigned rom(int unsigned i);
      int unsigned r;
      r = (i < ROM_LEN) ? CAL_ROM[i] : 65535;
      return r;
    endfunction

    function int unsigned lookup_tenths(int unsigned q);
      int unsigned lo, hi, b, sl, sh, span, frac;
      if (q > 9126 && q < rom(0)) return 0;
      for (int seg = 0; seg <= LAST_SEG; seg++) begin
        lo = rom(seg * STEPS_PER_SEG);
        hi = rom((seg + 1) * STEPS_PER_SEG);
        if (q >= lo && q < hi) begin
          b = seg * STEPS_PER_SEG;
          for (int s = 0; s < STEPS_PER_SEG; s++) begin
            sl = rom(b + s);
            sh = rom(b + s + 1);
            if (q >= sl && q < sh) begin
              span = sh - sl;
              frac = (span == 0) ? 0 : ((q - sl) * 10) / span;
              return seg * 100 + s * 10 + frac;
            end
          end
          return 0;
        end
      end
      return 9999;
    endfunction

    function void note_code(logic [23:0] code);
      longint unsigned raw;
      int unsigned     q, tn, t;
      reading_t        r;
      raw = code[23] ? 0 : code;
      q = (raw * 25000) / 8388607;
      tn = lookup_tenths(q);
      t = tn;
      if (t > gate) t = (t > trim) ? t - trim : 0;
      if (t > disc_limit) begin
        r.temp = disc_code[15:0]; r.ok = 1'b0;
      end else begin
        r.temp = ((t / 10) > vmax) ? clamp_code[15:0] : 16'(t / 10);
        r.ok = 1'b1;
      end
      r.tenths = tn[13:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] d);
      reading_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.temp) begin
        $display("%0t: temp exp %0d got %0d", $realtime, e.temp, d[15:0]);
        errors++;
      end
      if (d[29:16] !== e.tenths) begin
        $display("%0t: tenths exp %0d got %0d", $realtime, e.tenths, d[29:16]);
        errors++;
      end
      if (d[30] !== e.ok) begin
        $display("%0t: read_ok exp %0d got %0d", $realtime, e.ok, d[30]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst_n = 0;
  logic        in_tvalid = 0, in_tready;
  logic [23:0] in_tdata = 0;
  logic        out_tvalid, out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  bit          calm = 0;
  reading_board sb;

  adc_code_to_temperature_lut_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // map a table code back onto a raw ADC code that lands on it
  function automatic logic [23:0] code_for_q(int unsigned q);
    longint unsigned r;
    r = (longint'(q) * 8388607 + 24999) / 25000;
    if (r > 8388607) r = 8388607;
    return r[23:0];
  endfunction

  // drive at the falling edge; back-to-back calls may raise and drop valid in one step
  task automatic send_code(logic [23:0] code);
    while (!calm && $urandom_range(99) < 30) @(negedge clk);
    in_tvalid = 1; in_tdata = code;
    do @(posedge clk); while (!in_tready);
    sb.note_code(code);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic random_codes(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 6) send_code(code_for_q($urandom_range(18100, 9000)));
      else if (k < 8) send_code(24'($urandom()));
      else send_code(24'(code_for_q($urandom_range(25000)) + $urandom_range(1)));
    end
  endtask

  // sample and check results; receiver stalls randomly unless calm is set
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end
  always @(negedge clk) out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

  initial begin
    #4000000;
    $display("tb_adc_code_to_temperature_lut_unit: done, errors");
    $finish;
  end

  initial begin
    sb = new();
    sb.defaults();
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // extremes, table edges, zero span, gap, over-range
    send_code(24'h000000); send_code(24'h7FFFFF); send_code(24'h800000);
    send_code(24'hFFFFFF); send_code(code_for_q(9126)); send_code(code_for_q(9127));
    send_code(code_for_q(9999)); send_code(code_for_q(10000));
    send_code(code_for_q(16105)); send_code(code_for_q(16104));
    send_code(code_for_q(17952)); send_code(code_for_q(17953));
    send_code(code_for_q(13050)); send_code(24'h555555); send_code(24'h2AAAAA);
    drain();

    // trim saturation and disconnect
    write_reg(REG_TRIM, 16'd255); write_reg(REG_TRIM_GATE, 16'd0);
    write_reg(REG_DISC_LIMIT, 16'd500); write_reg(REG_VALID_MAX, 16'd20);
    write_reg(REG_DISC_CODE, 16'h1234); write_reg(REG_CLAMP_CODE, 16'd0);
    write_reg(3'd7, 16'hFFFF);
    send_code(code_for_q(10100)); send_code(code_for_q(13000));
    send_code(code_for_q(17000)); send_code(code_for_q(11000));
    send_code(code_for_q(25000));
    drain();

    random_codes(100);
    drain();
    write_reg(REG_TRIM, 16'd0); write_reg(REG_TRIM_GATE, 16'd9999);
    write_reg(REG_DISC_LIMIT, 16'd9999); write_reg(REG_VALID_MAX, 16'd999);
    write_reg(REG_DISC_CODE, 16'd0); write_reg(REG_CLAMP_CODE, 16'hFFFF);
    calm = 1;
    random_codes(60);
    calm = 0;
    drain();
    write_reg(REG_TRIM, 16'($urandom_range(255)));
    write_reg(REG_TRIM_GATE, 16'($urandom_range(2000)));
    write_reg(REG_DISC_LIMIT, 16'($urandom_range(9999, 3000)));
    write_reg(REG_VALID_MAX, 16'($urandom_range(999)));
    write_reg(REG_DISC_CODE, 16'($urandom()));
    write_reg(REG_CLAMP_CODE, 16'($urandom()));
    random_codes(120);
    drain();
    sb.defaults();
    for (int i = 0; i < 6; i++) write_reg(i[2:0], i == 4 ? 16'hFFFF : 16'h0);
    write_reg(REG_TRIM, 16'd25); write_reg(REG_TRIM_GATE, 16'd100);
    write_reg(REG_DISC_LIMIT, 16'd9000); write_reg(REG_VALID_MAX, 16'd390);
    write_reg(REG_CLAMP_CODE, 16'd390);
    random_codes(100);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_adc_code_to_temperature_lut_unit: done, clean");
    end else begin
      $display("tb_adc_code_to_temperature_lut_unit: done, errors");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/atlu_pkg.sv
rtl/atlu_ctrl.sv
rtl/atlu_datapath.sv
rtl/adc_code_to_temperature_lut_unit.sv
tb/tb_adc_code_to_temperature_lut_unit.sv
